FILE: sv/pdof_pkg.sv
`timescale 1ns / 1ps

package pdof_pkg;

    // Partition limits
    localparam int MAX_CELLS = 256;
    localparam int CELL_W    = 8;
    localparam int CNT_W     = 9;

    // Datapath widths (Q16.16 throughout)
    localparam int POS_W   = 32;
    localparam int TOL_W   = 16;
    localparam int RSUM_W  = 33;
    localparam int DIFF_W  = 35;
    localparam int MAG_W   = 34;
    localparam int HALF_W  = 17;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int RAD_W   = SQ_W + 1;
    localparam int RADP_W  = 72;
    localparam int ROOT_W  = RADP_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int PPS_W   = RSUM_W + HALF_W;
    localparam int PROD_W  = RSUM_W + MAG_W;
    localparam int QUO_W   = 33;
    localparam int DREM_W  = ROOT_W;
    localparam int FORCE_W = 34;
    localparam int CMP_W   = ROOT_W + 1;

    // Image shift per axis
    typedef enum logic [1:0] {
        SH_NONE,
        SH_SUB,
        SH_ADD,
        SH_MISS
    } shift_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CELLS_X = 2'd0,
        REG_CELLS_Y = 2'd1,
        REG_BOX     = 2'd2,
        REG_TOL     = 2'd3
    } reg_idx_t;

    // Values that ride along with the square root
    typedef struct packed {
        logic              contact;
        logic [RSUM_W-1:0] rsum;
        logic [MAG_W-1:0]  adx;
        logic [MAG_W-1:0]  ady;
        logic              negx;
        logic              negy;
    } side_t;

    // Choose the image of the second disk from the cell difference
    function automatic shift_t image_shift(logic [CELL_W-1:0] c1, logic [CELL_W-1:0] c2,
                                           logic [CNT_W-1:0] cells);
        logic [CELL_W-1:0] n;
        logic [CNT_W-1:0]  d;
        logic [CNT_W-1:0]  nn;
        shift_t            sh;
        if (cells == '0)
            n = '0;
        else if (cells > CNT_W'(MAX_CELLS))
            n = CELL_W'(MAX_CELLS - 1);
        else
            n = CELL_W'(cells - CNT_W'(1));
        d  = {1'b0, c2} - {1'b0, c1};
        nn = {1'b0, n};
        if (d == '0 || d == CNT_W'(1) || d == '1)
            sh = SH_NONE;
        else if (d == nn)
            sh = SH_SUB;
        else if (d == (~nn + CNT_W'(1)))
            sh = SH_ADD;
        else
            sh = SH_MISS;
        return sh;
    endfunction

endpackage

FILE: sv/pdof_front.sv
`timescale 1ns / 1ps

module pdof_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pdof_pkg::POS_W-1:0]          first_x,
    input  logic [pdof_pkg::POS_W-1:0]          first_y,
    input  logic [pdof_pkg::POS_W-1:0]          first_radius,
    input  logic [pdof_pkg::CELL_W-1:0]         first_cell_x,
    input  logic [pdof_pkg::CELL_W-1:0]         first_cell_y,
    input  logic [pdof_pkg::POS_W-1:0]          second_x,
    input  logic [pdof_pkg::POS_W-1:0]          second_y,
    input  logic [pdof_pkg::POS_W-1:0]          second_radius,
    input  logic [pdof_pkg::CELL_W-1:0]         second_cell_x,
    input  logic [pdof_pkg::CELL_W-1:0]         second_cell_y,
    input  logic [pdof_pkg::CNT_W-1:0]          cells_x,
    input  logic [pdof_pkg::CNT_W-1:0]          cells_y,
    input  logic [pdof_pkg::POS_W-1:0]          box_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pdof_pkg::RAD_W-1:0]          out_rad,
    output pdof_pkg::side_t                     out_side
);

    localparam int DW = pdof_pkg::DIFF_W;
    localparam int MW = pdof_pkg::MAG_W;
    localparam int HW = pdof_pkg::HALF_W;
    localparam int PW = MW + HW;
    localparam int SW = pdof_pkg::SQ_W;

    logic rdy_a, rdy_b, rdy_c;

    // Stage A: image choice and signed differences
    logic                          a_v_reg;
    logic                          a_contact_reg;
    logic [DW-1:0]                 a_dx_reg, a_dy_reg;
    logic [pdof_pkg::RSUM_W-1:0]   a_rsum_reg;
    pdof_pkg::shift_t              shx, shy;
    logic [DW-1:0]                 a_dx_next, a_dy_next;

    function automatic logic [DW-1:0] axis_diff(logic [pdof_pkg::POS_W-1:0] p1,
                                                logic [pdof_pkg::POS_W-1:0] p2,
                                                logic [pdof_pkg::POS_W-1:0] box,
                                                pdof_pkg::shift_t sh);
        logic [DW-1:0] base;
        logic [DW-1:0] r;
        base = DW'(p1) - DW'(p2);
        unique case (sh)
            pdof_pkg::SH_SUB: r = base + DW'(box);
            pdof_pkg::SH_ADD: r = base - DW'(box);
            default:          r = base;
        endcase
        return r;
    endfunction

    always_comb
    begin
        shx       = pdof_pkg::image_shift(first_cell_x, second_cell_x, cells_x);
        shy       = pdof_pkg::image_shift(first_cell_y, second_cell_y, cells_y);
        a_dx_next = axis_diff(first_x, second_x, box_length, shx);
        a_dy_next = axis_diff(first_y, second_y, box_length, shy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (rdy_a)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            a_contact_reg <= (shx != pdof_pkg::SH_MISS) && (shy != pdof_pkg::SH_MISS);
            a_dx_reg      <= a_dx_next;
            a_dy_reg      <= a_dy_next;
            a_rsum_reg    <= pdof_pkg::RSUM_W'(first_radius) + pdof_pkg::RSUM_W'(second_radius);
        end
    end

    // Stage B: magnitudes and half-width partial products of the squares
    logic                          b_v_reg;
    logic                          b_contact_reg;
    logic [pdof_pkg::RSUM_W-1:0]   b_rsum_reg;
    logic [MW-1:0]                 b_adx_reg, b_ady_reg;
    logic                          b_negx_reg, b_negy_reg;
    logic [PW-1:0]                 b_pxl_reg, b_pxh_reg, b_pyl_reg, b_pyh_reg;
    logic [MW-1:0]                 adx, ady;

    always_comb
    begin
        adx = a_dx_reg[DW-1] ? MW'(~a_dx_reg + DW'(1)) : MW'(a_dx_reg);
        ady = a_dy_reg[DW-1] ? MW'(~a_dy_reg + DW'(1)) : MW'(a_dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (rdy_b)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && a_v_reg)
        begin
            b_contact_reg <= a_contact_reg;
            b_rsum_reg    <= a_rsum_reg;
            b_adx_reg     <= adx;
            b_ady_reg     <= ady;
            b_negx_reg    <= a_dx_reg[DW-1];
            b_negy_reg    <= a_dy_reg[DW-1];
            b_pxl_reg     <= PW'(adx) * PW'(adx[HW-1:0]);
            b_pxh_reg     <= PW'(adx) * PW'(adx[MW-1:HW]);
            b_pyl_reg     <= PW'(ady) * PW'(ady[HW-1:0]);
            b_pyh_reg     <= PW'(ady) * PW'(ady[MW-1:HW]);
        end
    end

    // Stage C: recombine the squares and sum them
    logic                          c_v_reg;
    logic [pdof_pkg::RAD_W-1:0]    c_rad_reg;
    pdof_pkg::side_t               c_side_reg;
    logic [SW-1:0]                 sqx, sqy;

    always_comb
    begin
        sqx = SW'(b_pxl_reg) + {b_pxh_reg, HW'(0)};
        sqy = SW'(b_pyl_reg) + {b_pyh_reg, HW'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (rdy_c)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && b_v_reg)
        begin
            c_rad_reg          <= pdof_pkg::RAD_W'(sqx) + pdof_pkg::RAD_W'(sqy);
            c_side_reg.contact <= b_contact_reg;
            c_side_reg.rsum    <= b_rsum_reg;
            c_side_reg.adx     <= b_adx_reg;
            c_side_reg.ady     <= b_ady_reg;
            c_side_reg.negx    <= b_negx_reg;
            c_side_reg.negy    <= b_negy_reg;
        end
    end

    // A stage moves on when it is empty or the next one moves
    assign rdy_c     = !c_v_reg || out_ready;
    assign rdy_b     = !b_v_reg || rdy_c;
    assign rdy_a     = !a_v_reg || rdy_b;
    assign in_ready  = rdy_a;
    assign out_valid = c_v_reg;
    assign out_rad   = c_rad_reg;
    assign out_side  = c_side_reg;

endmodule

FILE: sv/pdof_sqrt.sv
`timescale 1ns / 1ps

module pdof_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pdof_pkg::RAD_W-1:0]      in_rad,
    input  pdof_pkg::side_t                 in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pdof_pkg::ROOT_W-1:0]     out_dist,
    output pdof_pkg::side_t                 out_side
);

    localparam int N  = pdof_pkg::ROOT_W;
    localparam int PW = pdof_pkg::RADP_W;
    localparam int RW = pdof_pkg::REM_W;

    // One root bit per stage, restoring digit recurrence
    logic                   v_reg    [N];
    logic [PW-1:0]          rad_reg  [N];
    logic [RW-1:0]          rem_reg  [N];
    logic [N-1:0]           root_reg [N];
    pdof_pkg::side_t        side_reg [N];
    logic                   rdy      [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic            src_v;
            logic [PW-1:0]   src_rad;
            logic [RW-1:0]   src_rem;
            logic [N-1:0]    src_root;
            pdof_pkg::side_t src_side;
            logic [RW-1:0]   cur, trial;
            logic            ge;

            if (i == 0)
            begin : g_src_in
                always_comb
                begin
                    src_v    = in_valid;
                    src_rad  = PW'(in_rad);
                    src_rem  = '0;
                    src_root = '0;
                    src_side = in_side;
                end
            end
            else
            begin : g_src_prev
                always_comb
                begin
                    src_v    = v_reg[i-1];
                    src_rad  = rad_reg[i-1];
                    src_rem  = rem_reg[i-1];
                    src_root = root_reg[i-1];
                    src_side = side_reg[i-1];
                end
            end

            if (i == N - 1)
            begin : g_rdy_last
                assign rdy[i] = !v_reg[i] || out_ready;
            end
            else
            begin : g_rdy_mid
                assign rdy[i] = !v_reg[i] || rdy[i+1];
            end

            always_comb
            begin
                cur   = {src_rem[RW-3:0], src_rad[PW-1 -: 2]};
                trial = {2'b00, src_root, 2'b01};
                ge    = (cur >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (rdy[i])
                    v_reg[i] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i] && src_v)
                begin
                    rad_reg[i]  <= {src_rad[PW-3:0], 2'b00};
                    rem_reg[i]  <= ge ? (cur - trial) : cur;
                    root_reg[i] <= {src_root[N-2:0], ge};
                    side_reg[i] <= src_side;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign out_dist  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

FILE: sv/pdof_div.sv
`timescale 1ns / 1ps

module pdof_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pdof_pkg::ROOT_W-1:0]         in_dist,
    input  pdof_pkg::side_t                     in_side,
    input  logic [pdof_pkg::TOL_W-1:0]          overlap_tolerance,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                overlap,
    output logic signed [pdof_pkg::FORCE_W-1:0] force_x,
    output logic signed [pdof_pkg::FORCE_W-1:0] force_y,
    output logic                                coincident
);

    localparam int DL  = pdof_pkg::ROOT_W;
    localparam int QW  = pdof_pkg::QUO_W;
    localparam int RMW = pdof_pkg::DREM_W;
    localparam int PPW = pdof_pkg::PPS_W;
    localparam int PRW = pdof_pkg::PROD_W;
    localparam int HW  = pdof_pkg::HALF_W;
    localparam int MW  = pdof_pkg::MAG_W;
    localparam int FW  = pdof_pkg::FORCE_W;
    localparam int CW  = pdof_pkg::CMP_W;

    typedef struct packed {
        logic           ov;
        logic           coin;
        logic           negx;
        logic           negy;
        logic [DL-1:0]  span;
        logic [RMW-1:0] remx;
        logic [RMW-1:0] remy;
        logic [QW-1:0]  lowx;
        logic [QW-1:0]  lowy;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
    } dstage_t;

    logic rdy_m1, rdy_m2, rdy_f;

    // Stage M1: overlap test and partial products of rsum * |d|
    logic            m1_v_reg;
    logic            m1_ov_reg, m1_coin_reg, m1_negx_reg, m1_negy_reg;
    logic [DL-1:0]   m1_dist_reg;
    logic [PPW-1:0]  m1_pxl_reg, m1_pxh_reg, m1_pyl_reg, m1_pyh_reg;
    logic            ov;

    always_comb
    begin
        ov = in_side.contact &&
             (CW'(in_dist) < (CW'(in_side.rsum) + CW'(overlap_tolerance)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= 1'b0;
        else if (rdy_m1)
            m1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_m1 && in_valid)
        begin
            m1_ov_reg   <= ov;
            m1_coin_reg <= ov && (in_dist == '0);
            m1_negx_reg <= in_side.negx;
            m1_negy_reg <= in_side.negy;
            m1_dist_reg <= in_dist;
            m1_pxl_reg  <= PPW'(in_side.rsum) * PPW'(in_side.adx[HW-1:0]);
            m1_pxh_reg  <= PPW'(in_side.rsum) * PPW'(in_side.adx[MW-1:HW]);
            m1_pyl_reg  <= PPW'(in_side.rsum) * PPW'(in_side.ady[HW-1:0]);
            m1_pyh_reg  <= PPW'(in_side.rsum) * PPW'(in_side.ady[MW-1:HW]);
        end
    end

    // Stage M2: full products, split into starting remainder and dividend tail
    logic            m2_v_reg;
    dstage_t         m2_reg;
    logic [PRW-1:0]  nx, ny;

    always_comb
    begin
        nx = PRW'(m1_pxl_reg) + {m1_pxh_reg, HW'(0)};
        ny = PRW'(m1_pyl_reg) + {m1_pyh_reg, HW'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_v_reg <= 1'b0;
        else if (rdy_m2)
            m2_v_reg <= m1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_m2 && m1_v_reg)
        begin
            m2_reg.ov   <= m1_ov_reg;
            m2_reg.coin <= m1_coin_reg;
            m2_reg.negx <= m1_negx_reg;
            m2_reg.negy <= m1_negy_reg;
            m2_reg.span <= m1_dist_reg;
            m2_reg.remx <= RMW'(nx[PRW-1:QW]);
            m2_reg.remy <= RMW'(ny[PRW-1:QW]);
            m2_reg.lowx <= nx[QW-1:0];
            m2_reg.lowy <= ny[QW-1:0];
            m2_reg.qx   <= '0;
            m2_reg.qy   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage on both axes
    logic    v_reg [QW];
    dstage_t d_reg [QW];
    logic    rdy   [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            logic             src_v;
            dstage_t          src;
            logic [RMW:0]     curx, cury, dd;
            logic             gex, gey;

            if (i == 0)
            begin : g_src_m2
                always_comb
                begin
                    src_v = m2_v_reg;
                    src   = m2_reg;
                end
            end
            else
            begin : g_src_prev
                always_comb
                begin
                    src_v = v_reg[i-1];
                    src   = d_reg[i-1];
                end
            end

            if (i == QW - 1)
            begin : g_rdy_last
                assign rdy[i] = !v_reg[i] || rdy_f;
            end
            else
            begin : g_rdy_mid
                assign rdy[i] = !v_reg[i] || rdy[i+1];
            end

            always_comb
            begin
                curx = {src.remx, src.lowx[QW-1]};
                cury = {src.remy, src.lowy[QW-1]};
                dd   = (RMW + 1)'(src.span);
                gex  = (curx >= dd);
                gey  = (cury >= dd);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (rdy[i])
                    v_reg[i] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i] && src_v)
                begin
                    d_reg[i].ov   <= src.ov;
                    d_reg[i].coin <= src.coin;
                    d_reg[i].negx <= src.negx;
                    d_reg[i].negy <= src.negy;
                    d_reg[i].span <= src.span;
                    d_reg[i].remx <= RMW'(gex ? (curx - dd) : curx);
                    d_reg[i].remy <= RMW'(gey ? (cury - dd) : cury);
                    d_reg[i].lowx <= {src.lowx[QW-2:0], 1'b0};
                    d_reg[i].lowy <= {src.lowy[QW-2:0], 1'b0};
                    d_reg[i].qx   <= {src.qx[QW-2:0], gex};
                    d_reg[i].qy   <= {src.qy[QW-2:0], gey};
                end
            end
        end
    endgenerate

    // Output register: sign the quotients and clear them when there is no force
    logic                 f_v_reg;
    logic                 f_ov_reg, f_coin_reg;
    logic [FW-1:0]        f_fx_reg, f_fy_reg;
    logic                 live;
    logic [FW-1:0]        fx, fy;
    dstage_t              last;

    always_comb
    begin
        last = d_reg[QW-1];
        live = last.ov && !last.coin;
        fx   = last.negx ? (~FW'(last.qx) + FW'(1)) : FW'(last.qx);
        fy   = last.negy ? (~FW'(last.qy) + FW'(1)) : FW'(last.qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (rdy_f)
            f_v_reg <= v_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_f && v_reg[QW-1])
        begin
            f_ov_reg   <= last.ov;
            f_coin_reg <= last.coin;
            f_fx_reg   <= live ? fx : '0;
            f_fy_reg   <= live ? fy : '0;
        end
    end

    assign rdy_f      = !f_v_reg || out_ready;
    assign rdy_m2     = !m2_v_reg || rdy[0];
    assign rdy_m1     = !m1_v_reg || rdy_m2;
    assign in_ready   = rdy_m1;
    assign out_valid  = f_v_reg;
    assign overlap    = f_ov_reg;
    assign coincident = f_coin_reg;
    assign force_x    = signed'(f_fx_reg);
    assign force_y    = signed'(f_fy_reg);

endmodule

FILE: sv/periodic_disk_overlap_force_top.sv
`timescale 1ns / 1ps

// Channel   Handshake               Beat
// in        in_valid / in_stall     one disk pair (positions, radii, cells)
// out       out_valid / out_stall   overlap, force_x, force_y, coincident
// cfg       cfg_we                  cfg_index selects register, cfg_data value
//
// One pair enters per cycle while not stalled; each beat passes through:
// 3 front stages (image, squares), 36 square-root stages (one root bit each),
// 36 divider stages (product, 33 quotient bits, output register).
// Reset clears only the stage valid bits and the configuration registers.
// A stall on out holds the output register; empty stages upstream still fill,
// so in_stall rises only when every stage holds a beat.

module periodic_disk_overlap_force_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [pdof_pkg::POS_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pdof_pkg::POS_W-1:0]          first_x,
    input  logic [pdof_pkg::POS_W-1:0]          first_y,
    input  logic [pdof_pkg::POS_W-1:0]          first_radius,
    input  logic [pdof_pkg::CELL_W-1:0]         first_cell_x,
    input  logic [pdof_pkg::CELL_W-1:0]         first_cell_y,
    input  logic [pdof_pkg::POS_W-1:0]          second_x,
    input  logic [pdof_pkg::POS_W-1:0]          second_y,
    input  logic [pdof_pkg::POS_W-1:0]          second_radius,
    input  logic [pdof_pkg::CELL_W-1:0]         second_cell_x,
    input  logic [pdof_pkg::CELL_W-1:0]         second_cell_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                overlap,
    output logic signed [pdof_pkg::FORCE_W-1:0] force_x,
    output logic signed [pdof_pkg::FORCE_W-1:0] force_y,
    output logic                                coincident
);

    // Configuration registers
    logic [pdof_pkg::CNT_W-1:0] cells_x_reg, cells_y_reg;
    logic [pdof_pkg::POS_W-1:0] box_reg;
    logic [pdof_pkg::TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= pdof_pkg::CNT_W'(1);
            cells_y_reg <= pdof_pkg::CNT_W'(1);
            box_reg     <= '0;
            tol_reg     <= pdof_pkg::TOL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (pdof_pkg::reg_idx_t'(cfg_index))
                pdof_pkg::REG_CELLS_X: cells_x_reg <= cfg_data[pdof_pkg::CNT_W-1:0];
                pdof_pkg::REG_CELLS_Y: cells_y_reg <= cfg_data[pdof_pkg::CNT_W-1:0];
                pdof_pkg::REG_BOX:     box_reg     <= cfg_data;
                pdof_pkg::REG_TOL:     tol_reg     <= cfg_data[pdof_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage chain
    logic                        fr_ready, fr_valid;
    logic [pdof_pkg::RAD_W-1:0]  fr_rad;
    pdof_pkg::side_t             fr_side;
    logic                        sq_ready, sq_valid;
    logic [pdof_pkg::ROOT_W-1:0] sq_dist;
    pdof_pkg::side_t             sq_side;
    logic                        dv_ready;

    pdof_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (fr_ready),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_radius  (first_radius),
        .first_cell_x  (first_cell_x),
        .first_cell_y  (first_cell_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_radius (second_radius),
        .second_cell_x (second_cell_x),
        .second_cell_y (second_cell_y),
        .cells_x       (cells_x_reg),
        .cells_y       (cells_y_reg),
        .box_length    (box_reg),
        .out_valid     (fr_valid),
        .out_ready     (sq_ready),
        .out_rad       (fr_rad),
        .out_side      (fr_side)
    );

    pdof_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (sq_ready),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_ready (dv_ready),
        .out_dist  (sq_dist),
        .out_side  (sq_side)
    );

    pdof_div u_div (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (sq_valid),
        .in_ready          (dv_ready),
        .in_dist           (sq_dist),
        .in_side           (sq_side),
        .overlap_tolerance (tol_reg),
        .out_valid         (out_valid),
        .out_ready         (!out_stall),
        .overlap           (overlap),
        .force_x           (force_x),
        .force_y           (force_y),
        .coincident        (coincident)
    );

    assign in_stall = !fr_ready;

`ifndef SYNTHESIS
    // A coincident pair is always an overlapping pair
    a_coin_ov: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && coincident |-> overlap)
        else $error("coincident without overlap");

    // No force without an overlap
    a_no_ov_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overlap |-> (force_x == '0) && (force_y == '0))
        else $error("force without overlap");

    // Zero distance gives zero force
    a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && coincident |-> (force_x == '0) && (force_y == '0))
        else $error("force at zero distance");

    // The input side only stalls when the pipe is full and the output held
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipe");
`endif

endmodule
